>>> hw/rtl/positional_list_store_top_defines.svh
// Assertion macros shared by the positional list store RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising edge, off during reset.
`define PLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list store: implication check failed");
// Next-cycle implication, sampled on the rising edge, off during reset.
`define PLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list store: next-cycle check failed");
`else
`define PLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/pls_pkg.sv
// Package for the positional list store: command and status codes,
// request and result structs and the sequencer state type. No dependencies.
package pls_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LENGTH = 2'd2,
        CMD_STREAM = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] entry;
        logic [6:0]         length;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WRITE,
        S_SHIFT_DOWN,
        S_STREAM,
        S_DRAIN
    } t_state;

endpackage

>>> hw/rtl/pls_step.sv
// Shared address step unit: one increment or decrement and one equality compare.
// Uses no package; driven by the list sequencer.
module pls_step #(
    parameter int AW = 5
) (
    input  logic [AW-1:0] i_src,
    input  logic          i_up,
    input  logic [AW-1:0] i_bound,
    output logic [AW-1:0] o_next,
    output logic          o_hit
);

    // Next address in the walk direction, and end-of-walk detection.
    assign o_next = i_up ? (i_src + AW'(1)) : (i_src - AW'(1));
    assign o_hit  = (i_src == i_bound);

endmodule

>>> hw/rtl/pls_ram.sv
// Entry memory of the positional list store: one write and one read port,
// registered read data. Uses no package.
module pls_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pls_ctrl.sv
// Sequencer of the positional list store: decodes requests, walks the entry
// memory with the shared step unit and forms results. Depends on pls_pkg, pls_step.
`include "positional_list_store_top_defines.svh"
module pls_ctrl
    import pls_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  t_request                               i_req,
    output logic                                   o_busy,
    output logic                                   o_strobe,
    output t_result                                o_result,
    output logic                                   o_we,
    output logic [$clog2(CAPACITY)-1:0]            o_waddr,
    output logic signed [31:0]                     o_wdata,
    output logic [$clog2(CAPACITY)-1:0]            o_raddr,
    input  logic signed [31:0]                     i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_src, n_src;
    logic [AW-1:0]      r_prev, n_prev;
    logic [AW-1:0]      r_bound, n_bound;
    logic signed [31:0] r_value, n_value;
    logic               r_we, n_we;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic               r_wr_value, n_wr_value;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;
    logic               r_strobe, n_strobe;
    t_result            r_result, n_result;

    logic [7:0]         w_pos_ext;
    logic [7:0]         w_cnt_ext;
    logic [5:0]         w_pos_m1;
    logic [CW-1:0]      w_cnt_m1;
    logic [CW-1:0]      w_cnt_p1;
    logic               w_up;
    logic [AW-1:0]      w_next;
    logic               w_hit;

    // Shared step unit: walks down for an insert, up for delete and stream.
    assign w_up = (r_state != S_SHIFT_UP);

    pls_step #(
        .AW (AW)
    ) u_step (
        .i_src   (r_src),
        .i_up    (w_up),
        .i_bound (r_bound),
        .o_next  (w_next),
        .o_hit   (w_hit)
    );

    // Operand forms used by the range checks.
    assign w_pos_ext = {2'b00, i_req.position};
    assign w_cnt_ext = 8'(r_count);
    assign w_pos_m1  = i_req.position - 6'd1;
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_cnt_p1  = r_count + CW'(1);

    // Memory port: reads follow the walk pointer, write data is the held request value or the entry just read.
    assign o_raddr = r_src;
    assign o_we    = r_we;
    assign o_waddr = r_waddr;
    assign o_wdata = r_wr_value ? r_value : i_rdata;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_we     <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_we     <= n_we;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_prev      <= n_prev;
        r_bound     <= n_bound;
        r_value     <= n_value;
        r_waddr     <= n_waddr;
        r_wr_value  <= n_wr_value;
        r_pend_last <= n_pend_last;
        r_result    <= n_result;
    end

    // Next state, memory requests and results.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_src       = r_src;
        n_prev      = r_prev;
        n_bound     = r_bound;
        n_value     = r_value;
        n_we        = 1'b0;
        n_waddr     = r_waddr;
        n_wr_value  = r_wr_value;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_strobe    = 1'b0;
        n_result    = r_result;

        // A streamed entry read in the previous cycle is sent out now.
        if (r_pend) begin
            n_strobe = 1'b1;
            n_result = '{status: ST_OK, entry: i_rdata, length: 7'(r_count),
                         last: r_pend_last};
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.command)
                        CMD_INSERT: begin
                            n_strobe = 1'b1;
                            n_result = '{status: ST_OK, entry: '0,
                                         length: 7'(r_count), last: 1'b1};
                            if (r_count >= CW'(CAPACITY)) begin
                                n_result.status = ST_FULL;
                            end else if (i_req.position == 6'd0 ||
                                         w_pos_ext > (w_cnt_ext + 8'd1)) begin
                                n_result.status = ST_BAD_POS;
                            end else if (w_pos_ext == (w_cnt_ext + 8'd1)) begin
                                // Append: no entries move.
                                n_we            = 1'b1;
                                n_waddr         = r_count[AW-1:0];
                                n_wr_value      = 1'b1;
                                n_value         = i_req.value;
                                n_count         = w_cnt_p1;
                                n_result.length = 7'(w_cnt_p1);
                            end else begin
                                n_strobe   = 1'b0;
                                n_value    = i_req.value;
                                n_bound    = w_pos_m1[AW-1:0];
                                n_src      = w_cnt_m1[AW-1:0];
                                n_prev     = r_count[AW-1:0];
                                n_state    = S_SHIFT_UP;
                            end
                        end
                        CMD_DELETE: begin
                            n_strobe = 1'b1;
                            n_result = '{status: ST_OK, entry: '0,
                                         length: 7'(r_count), last: 1'b1};
                            if (r_count == '0) begin
                                n_result.status = ST_EMPTY;
                            end else if (i_req.position == 6'd0 ||
                                         w_pos_ext > w_cnt_ext) begin
                                n_result.status = ST_BAD_POS;
                            end else if (w_pos_ext == w_cnt_ext) begin
                                // Removing the tail: no entries move.
                                n_count         = w_cnt_m1;
                                n_result.length = 7'(w_cnt_m1);
                            end else begin
                                n_strobe = 1'b0;
                                n_src    = i_req.position[AW-1:0];
                                n_prev   = w_pos_m1[AW-1:0];
                                n_bound  = w_cnt_m1[AW-1:0];
                                n_state  = S_SHIFT_DOWN;
                            end
                        end
                        CMD_LENGTH: begin
                            n_strobe = 1'b1;
                            n_result = '{status: ST_OK, entry: '0,
                                         length: 7'(r_count), last: 1'b1};
                        end
                        CMD_STREAM: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result = '{status: ST_EMPTY, entry: '0,
                                             length: 7'd0, last: 1'b1};
                            end else begin
                                n_src   = '0;
                                n_bound = w_cnt_m1[AW-1:0];
                                n_state = S_STREAM;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                // Entry read here lands one place higher in the next cycle.
                n_we       = 1'b1;
                n_waddr    = r_prev;
                n_wr_value = 1'b0;
                n_prev     = r_src;
                n_src      = w_next;
                if (w_hit) begin
                    n_state = S_INS_WRITE;
                end
            end
            S_INS_WRITE: begin
                // The new value goes into the gap left by the shift.
                n_we       = 1'b1;
                n_waddr    = r_bound;
                n_wr_value = 1'b1;
                n_count    = w_cnt_p1;
                n_strobe   = 1'b1;
                n_result   = '{status: ST_OK, entry: '0,
                               length: 7'(w_cnt_p1), last: 1'b1};
                n_state    = S_IDLE;
            end
            S_SHIFT_DOWN: begin
                // Entry read here lands one place lower in the next cycle.
                n_we       = 1'b1;
                n_waddr    = r_prev;
                n_wr_value = 1'b0;
                n_prev     = r_src;
                n_src      = w_next;
                if (w_hit) begin
                    n_count  = w_cnt_m1;
                    n_strobe = 1'b1;
                    n_result = '{status: ST_OK, entry: '0,
                                 length: 7'(w_cnt_m1), last: 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_STREAM: begin
                n_pend      = 1'b1;
                n_pend_last = w_hit;
                n_src       = w_next;
                if (w_hit) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Checks on the sequencer.
    `PLS_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `PLS_ASSERT_IMP(a_waddr_in_range, i_clk, i_rst_n, r_we, r_waddr <= AW'(CAPACITY - 1))
    `PLS_ASSERT_NXT(a_stream_unbroken, i_clk, i_rst_n, r_strobe && !r_result.last, r_strobe)
    `PLS_ASSERT_IMP(a_no_pend_idle, i_clk, i_rst_n, r_state == S_IDLE, !r_pend)

endmodule

>>> hw/rtl/positional_list_store_top.sv
// Top level of the positional list store: an ordered list of signed words.
// Depends on pls_pkg, pls_ctrl and pls_ram.
//
// Usage: a request (insert, delete, report length, stream) is taken on a rising
// edge with start high and busy low. Results leave on o_result, each valid for
// exactly one cycle while o_strobe is high; the receiver cannot hold them off.
// Every request ends with a result whose last flag is set.
// Results, with p the position in the request:
//   report, append, tail delete and every error: result in the cycle after
//   the request, busy never rises;
//   insert inside the list: busy rises while entries from position p up
//   move one place higher, then the new value goes into the gap;
//   delete inside the list: busy rises while entries above p move down;
//   stream: one entry a cycle, each via the memory read and result registers.
// The single write port of the entry memory and the shared step unit move
// the entries of a shift one entry a cycle.
// Reset empties the list; no memory clearing is needed, as only entries that
// have been written are ever read.
module positional_list_store_top
    import pls_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_item,
    output logic     busy,
    output logic     o_strobe,
    output t_result  o_result
);

    localparam int AW = $clog2(CAPACITY);

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic [AW-1:0]      w_raddr;
    logic signed [31:0] w_rdata;

    // Sequencer with the shared step unit.
    pls_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_item),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    // Entry memory.
    pls_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

>>> test/tb.sv
// Self-checking testbench for positional_list_store_top: directed and random list commands.
// Depends on pls_pkg and the positional list store RTL; it reads no files.
module tb;
    import pls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 160;
    localparam int SETTLE_WAIT  = 2 * CAPACITY + 8;

    // Mirror of the list that also keeps the results still to come, oldest first.
    class list_tracker;
        logic signed [31:0] held_values[$];
        t_result            awaited_results[$];
        int unsigned        mismatches;
        int                 capacity;

        function new(int cap);
            capacity   = cap;
            mismatches = 0;
        endfunction

        function int held_count();
            return held_values.size();
        endfunction

        function int awaited_count();
            return awaited_results.size();
        endfunction

        function void await_result(t_status st, logic signed [31:0] ent, int n, logic lst);
            t_result r;
            r.status = st;
            r.entry  = ent;
            r.length = 7'(n);
            r.last   = lst;
            awaited_results.push_back(r);
        endfunction

        // Apply one accepted request to the mirror and queue the results it causes.
        function void note_request(t_request req);
            int n;
            int p;
            n = held_values.size();
            p = int'(req.position);
            case (req.command)
                CMD_INSERT: begin
                    // A full list is reported before the position is looked at.
                    if (n >= capacity) begin
                        await_result(ST_FULL, 0, n, 1'b1);
                    end else if (p < 1 || p > n + 1) begin
                        await_result(ST_BAD_POS, 0, n, 1'b1);
                    end else begin
                        held_values.insert(p - 1, req.value);
                        await_result(ST_OK, 0, n + 1, 1'b1);
                    end
                end
                CMD_DELETE: begin
                    // An empty list is reported before the position is looked at.
                    if (n == 0) begin
                        await_result(ST_EMPTY, 0, 0, 1'b1);
                    end else if (p < 1 || p > n) begin
                        await_result(ST_BAD_POS, 0, n, 1'b1);
                    end else begin
                        held_values.delete(p - 1);
                        await_result(ST_OK, 0, n - 1, 1'b1);
                    end
                end
                CMD_LENGTH: begin
                    await_result(ST_OK, 0, n, 1'b1);
                end
                default: begin
                    // Streaming an empty list gives a single empty status.
                    if (n == 0) begin
                        await_result(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++)
                            await_result(ST_OK, held_values[i], n, (i == n - 1));
                    end
                end
            endcase
        endfunction

        // Compare one result from the block with the oldest expectation.
        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d entry %0d length %0d last %0d",
                       got.status, got.entry, got.length, got.last);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.entry !== want.entry) begin
                $error("entry: expected %0d, got %0d", want.entry, got.entry);
                mismatches++;
            end
            if (got.length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, got.length);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_request i_item;
    logic     busy;
    logic     o_strobe;
    t_result  o_result;

    list_tracker tracker = new(CAPACITY);
    bit          growing = 1'b1;

    positional_list_store_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            tracker.check_result(o_result);
    end

    // Present a request and hold it until the block takes it; start stays high.
    task automatic send_request(input t_request req);
        start  <= 1'b1;
        i_item <= req;
        do
            @(posedge i_clk);
        while (busy);
        tracker.note_request(req);
    endtask

    task automatic send_cmd(input t_cmd c, input int p, input logic signed [31:0] v);
        t_request req;
        req.command  = c;
        req.position = 6'(p);
        req.value    = v;
        send_request(req);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_count() != 0)
            @(posedge i_clk);
    endtask

    // Random request that mostly fills the list, then mostly empties it, in turn.
    task automatic make_request(output t_request req);
        int n;
        int r;
        n = tracker.held_count();
        if (growing && n == CAPACITY && $urandom_range(0, 2) == 0)
            growing = 1'b0;
        else if (!growing && n == 0 && $urandom_range(0, 2) == 0)
            growing = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 70)
            req.command = growing ? CMD_INSERT : CMD_DELETE;
        else if (r < 80)
            req.command = growing ? CMD_DELETE : CMD_INSERT;
        else if (r < 90)
            req.command = CMD_LENGTH;
        else
            req.command = CMD_STREAM;
        // Mostly a legal position, sometimes anything the field can hold.
        if ($urandom_range(0, 99) < 85) begin
            if (req.command == CMD_INSERT)
                req.position = 6'($urandom_range(1, n + 1));
            else
                req.position = 6'($urandom_range(1, (n == 0) ? 1 : n));
        end else begin
            req.position = 6'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: req.value = 32'sh7FFF_FFFF;
                1: req.value = 32'sh8000_0000;
                2: req.value = '0;
                default: req.value = '1;
            endcase
        end else begin
            req.value = $urandom;
        end
    endtask

    // Stimulus: reset, directed cases, then random bursts.
    initial begin
        t_request req;
        int burst_left;
        int gap;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: report, stream and deletes that must be refused.
        send_cmd(CMD_LENGTH, 0, 0);
        send_cmd(CMD_STREAM, 0, 0);
        send_cmd(CMD_DELETE, 1, 32'sh1234_5678);
        send_cmd(CMD_DELETE, 0, 0);
        // Inserts at bad positions, at the front, the tail and the middle, then a stream.
        send_cmd(CMD_INSERT, 0, 5);
        send_cmd(CMD_INSERT, 2, 6);
        send_cmd(CMD_INSERT, 1, 32'sh7FFF_FFFF);
        send_cmd(CMD_INSERT, 2, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 1, -1);
        send_cmd(CMD_INSERT, 2, 0);
        send_cmd(CMD_INSERT, 63, 7);
        send_cmd(CMD_INSERT, 6, 8);
        send_cmd(CMD_STREAM, 0, 0);
        // Deletes at bad positions, in the middle, at the tail and at the front.
        send_cmd(CMD_DELETE, 0, 0);
        send_cmd(CMD_DELETE, 5, 0);
        send_cmd(CMD_DELETE, 2, 0);
        send_cmd(CMD_DELETE, 3, 0);
        send_cmd(CMD_LENGTH, 0, 0);
        send_cmd(CMD_STREAM, 63, 32'sh5555_AAAA);
        send_cmd(CMD_DELETE, 1, 0);
        send_cmd(CMD_DELETE, 1, 0);
        send_cmd(CMD_STREAM, 0, 0);
        drain_results();

        // Random requests in bursts, with one full drain halfway.
        burst_left = 0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                drain_results();
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                    idle_cycles(gap);
            end
            make_request(req);
            send_request(req);
            if (burst_left > 0)
                burst_left--;
        end

        drain_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.awaited_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Give up if the run hangs.
    initial begin
        #500_000;
        $display("tb: failure");
        $finish;
    end

endmodule
